/* src/ata_pio_lba28_transfer_sequencer_macros.svh */
// Assertion helpers for the transfer sequencer.
`ifndef ATA_PIO_LBA28_TRANSFER_SEQUENCER_MACROS_SVH
`define ATA_PIO_LBA28_TRANSFER_SEQUENCER_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ATA_ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true outside reset.
`define ATA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* src/ata_seq_pkg.sv */
package ata_seq_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int WIDX_W = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;

  localparam int MAX_RESULTS = 8;
  localparam int N_W = $clog2(MAX_RESULTS + 1);

  // field widths
  localparam int CMD_W   = 2;
  localparam int LBA_W   = 48;
  localparam int COUNT_W = 16;
  localparam int STAT_W  = 8;
  localparam int WORD_W  = 16;
  localparam int KIND_W  = 3;
  localparam int PORT_W  = 16;
  localparam int LBA28_W = 28;

  // configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IO_BASE = 1'b0;
  localparam logic REG_CONTROL = 1'b1;
  localparam logic [PORT_W-1:0] IO_BASE_RST = 16'h01F0;
  localparam logic [PORT_W-1:0] CONTROL_RST = 16'h03F6;

  // input item codes
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STATUS = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WORD   = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] K_PORT_WRITE = 3'd0;
  localparam logic [KIND_W-1:0] K_PORT_READ  = 3'd1;
  localparam logic [KIND_W-1:0] K_TO_HOST    = 3'd2;
  localparam logic [KIND_W-1:0] K_HOST_REQ   = 3'd3;
  localparam logic [KIND_W-1:0] K_DONE_OK    = 3'd4;
  localparam logic [KIND_W-1:0] K_DONE_ERR   = 3'd5;

  // task-file register offsets
  localparam logic [PORT_W-1:0] OFF_DATA     = 16'd0;
  localparam logic [PORT_W-1:0] OFF_SECCOUNT = 16'd2;
  localparam logic [PORT_W-1:0] OFF_LBA0     = 16'd3;
  localparam logic [PORT_W-1:0] OFF_LBA1     = 16'd4;
  localparam logic [PORT_W-1:0] OFF_LBA2     = 16'd5;
  localparam logic [PORT_W-1:0] OFF_DEVSEL   = 16'd6;
  localparam logic [PORT_W-1:0] OFF_CMD      = 16'd7;

  // device bytes
  localparam logic [7:0] DEV_LBA_MODE  = 8'hE0;
  localparam logic [7:0] ATA_CMD_READ  = 8'h20;
  localparam logic [7:0] ATA_CMD_WRITE = 8'h30;
  localparam logic [7:0] SEC_MAX       = 8'hFF;
  localparam int ST_BSY = 7;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PORT_W-1:0] port;
    logic [WORD_W-1:0] value;
  } res_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [LBA_W-1:0]   lba;
    logic [COUNT_W-1:0] count;
    logic [STAT_W-1:0]  status_byte;
    logic [WORD_W-1:0]  data_word;
  } item_t;

  typedef struct packed {
    logic                        load;
    logic [N_W-1:0]              n;
    res_t [MAX_RESULTS-1:0]      list;
  } job_t;

  typedef struct packed {
    logic [PORT_W-1:0] io_base;
    logic [PORT_W-1:0] control_port;
  } cfg_t;

  function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [PORT_W-1:0] port,
                                  logic [WORD_W-1:0] value);
    res_t r;
    r.kind  = kind;
    r.port  = port;
    r.value = value;
    return r;
  endfunction

endpackage

/* src/ata_seq_if.sv */
interface ata_seq_in_if;
  logic                             valid;
  logic                             ready;
  logic [ata_seq_pkg::CMD_W-1:0]    cmd;
  logic [ata_seq_pkg::LBA_W-1:0]    lba;
  logic [ata_seq_pkg::COUNT_W-1:0]  count;
  logic [ata_seq_pkg::STAT_W-1:0]   status_byte;
  logic [ata_seq_pkg::WORD_W-1:0]   data_word;

  modport source (output valid, cmd, lba, count, status_byte, data_word, input ready);
  modport sink (input valid, cmd, lba, count, status_byte, data_word, output ready);
endinterface

interface ata_seq_out_if;
  logic                            valid;
  logic                            ready;
  logic [ata_seq_pkg::KIND_W-1:0]  kind;
  logic [ata_seq_pkg::PORT_W-1:0]  port;
  logic [ata_seq_pkg::WORD_W-1:0]  value;
  logic                            last;

  modport source (output valid, kind, port, value, last, input ready);
  modport sink (input valid, kind, port, value, last, output ready);
endinterface

/* src/ata_seq_cfg.sv */
module ata_seq_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ata_seq_pkg::ADDR_W-1:0]    paddr,
  input  logic [ata_seq_pkg::DATA_W-1:0]    pwdata,
  output logic [ata_seq_pkg::DATA_W-1:0]    prdata,
  output ata_seq_pkg::cfg_t                 cfg
);

  logic [ata_seq_pkg::PORT_W-1:0] io_base_r;
  logic [ata_seq_pkg::PORT_W-1:0] control_r;
  logic                           wr_en;
  logic                           reg_sel;

  // registers sit on 4-byte boundaries
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_base_r <= ata_seq_pkg::IO_BASE_RST;
      control_r <= ata_seq_pkg::CONTROL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        ata_seq_pkg::REG_IO_BASE: io_base_r <= pwdata[ata_seq_pkg::PORT_W-1:0];
        ata_seq_pkg::REG_CONTROL: control_r <= pwdata[ata_seq_pkg::PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      ata_seq_pkg::REG_IO_BASE:
        prdata = {{(ata_seq_pkg::DATA_W-ata_seq_pkg::PORT_W){1'b0}}, io_base_r};
      ata_seq_pkg::REG_CONTROL:
        prdata = {{(ata_seq_pkg::DATA_W-ata_seq_pkg::PORT_W){1'b0}}, control_r};
      default: prdata = '0;
    endcase
  end

  assign cfg.io_base      = io_base_r;
  assign cfg.control_port = control_r;

endmodule

/* src/ata_seq_core.sv */
module ata_seq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ata_seq_pkg::item_t  item,
  input  ata_seq_pkg::cfg_t   cfg,
  output ata_seq_pkg::job_t   job
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_STATUS = 2'd1,
    PH_XFER   = 2'd2
  } phase_t;

  localparam int N_W = ata_seq_pkg::N_W;
  localparam logic [ata_seq_pkg::N_W-1:0]    N_ONE     = ata_seq_pkg::N_W'(1);
  localparam logic [ata_seq_pkg::N_W-1:0]    N_TWO     = ata_seq_pkg::N_W'(2);
  localparam logic [ata_seq_pkg::WIDX_W-1:0] WIDX_LAST =
    ata_seq_pkg::WIDX_W'(ata_seq_pkg::WORDS_PER_SECTOR - 1);

  phase_t                           phase_r, phase_nxt;
  logic                             writing_r, writing_nxt;
  logic                             bsc_r, bsc_nxt;
  logic [7:0]                       total_r, total_nxt;
  logic [7:0]                       sec_r, sec_nxt;
  logic [ata_seq_pkg::WIDX_W-1:0]   widx_r, widx_nxt;

  logic [7:0]                       n_sec;
  logic [ata_seq_pkg::PORT_W-1:0]   p_data;
  ata_seq_pkg::res_t                ask_status;
  ata_seq_pkg::res_t                ask_word;

  function automatic logic [ata_seq_pkg::PORT_W-1:0] byte16(logic [7:0] b);
    return {8'h00, b};
  endfunction

  assign p_data     = cfg.io_base + ata_seq_pkg::OFF_DATA;
  assign ask_status = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_READ,
                                          cfg.io_base + ata_seq_pkg::OFF_CMD, '0);
  assign ask_word   = writing_r ? ata_seq_pkg::mk_res(ata_seq_pkg::K_HOST_REQ, '0, '0)
                                : ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_READ, p_data, '0);
  assign n_sec      = (|item.count[15:8]) ? ata_seq_pkg::SEC_MAX : item.count[7:0];

  always_comb begin
    phase_nxt   = phase_r;
    writing_nxt = writing_r;
    bsc_nxt     = bsc_r;
    total_nxt   = total_r;
    sec_nxt     = sec_r;
    widx_nxt    = widx_r;
    job         = '0;

    unique case (item.cmd) inside
      ata_seq_pkg::CMD_READ, ata_seq_pkg::CMD_WRITE: begin
        if (phase_r != PH_STATUS && phase_r != PH_XFER) begin
          job.load = 1'b1;
          if (item.count == '0) begin
            job.n       = N_ONE;
            job.list[0] = ata_seq_pkg::mk_res(ata_seq_pkg::K_DONE_OK, '0, '0);
          end else if (|item.lba[ata_seq_pkg::LBA_W-1:ata_seq_pkg::LBA28_W]) begin
            job.n       = N_ONE;
            job.list[0] = ata_seq_pkg::mk_res(ata_seq_pkg::K_DONE_ERR, '0, '0);
          end else begin
            job.n       = N_W'(ata_seq_pkg::MAX_RESULTS);
            job.list[0] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                                              cfg.control_port, '0);
            job.list[1] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_DEVSEL,
                            byte16(ata_seq_pkg::DEV_LBA_MODE | {4'h0, item.lba[27:24]}));
            job.list[2] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_SECCOUNT, byte16(n_sec));
            job.list[3] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_LBA0, byte16(item.lba[7:0]));
            job.list[4] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_LBA1, byte16(item.lba[15:8]));
            job.list[5] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_LBA2, byte16(item.lba[23:16]));
            job.list[6] = ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE,
                            cfg.io_base + ata_seq_pkg::OFF_CMD,
                            byte16((item.cmd == ata_seq_pkg::CMD_WRITE) ?
                                   ata_seq_pkg::ATA_CMD_WRITE : ata_seq_pkg::ATA_CMD_READ));
            job.list[7] = ask_status;
            writing_nxt = (item.cmd == ata_seq_pkg::CMD_WRITE);
            total_nxt   = n_sec;
            sec_nxt     = '0;
            widx_nxt    = '0;
            bsc_nxt     = 1'b0;
            phase_nxt   = PH_STATUS;
          end
        end
      end
      ata_seq_pkg::CMD_STATUS: begin
        if (phase_r == PH_STATUS) begin
          job.load = 1'b1;
          job.n    = N_ONE;
          if (!bsc_r && item.status_byte[ata_seq_pkg::ST_BSY]) begin
            job.list[0] = ask_status;
          end else begin
            bsc_nxt = 1'b1;
            if (item.status_byte[ata_seq_pkg::ST_ERR]) begin
              job.list[0] = ata_seq_pkg::mk_res(ata_seq_pkg::K_DONE_ERR, '0, '0);
              phase_nxt   = PH_IDLE;
            end else if (item.status_byte[ata_seq_pkg::ST_DRQ]) begin
              job.list[0] = ask_word;
              widx_nxt    = '0;
              phase_nxt   = PH_XFER;
            end else begin
              job.list[0] = ask_status;
            end
          end
        end
      end
      ata_seq_pkg::CMD_WORD: begin
        if (phase_r == PH_XFER) begin
          job.load    = 1'b1;
          job.n       = N_TWO;
          job.list[0] = writing_r ?
                        ata_seq_pkg::mk_res(ata_seq_pkg::K_PORT_WRITE, p_data, item.data_word) :
                        ata_seq_pkg::mk_res(ata_seq_pkg::K_TO_HOST, '0, item.data_word);
          if (widx_r != WIDX_LAST) begin
            widx_nxt    = widx_r + ata_seq_pkg::WIDX_W'(1);
            job.list[1] = ask_word;
          end else begin
            widx_nxt = '0;
            sec_nxt  = sec_r + 8'd1;
            if (sec_nxt >= total_r) begin
              job.list[1] = ata_seq_pkg::mk_res(ata_seq_pkg::K_DONE_OK, '0, '0);
              phase_nxt   = PH_IDLE;
            end else begin
              job.list[1] = ask_status;
              bsc_nxt     = 1'b0;
              phase_nxt   = PH_STATUS;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      writing_r <= 1'b0;
      bsc_r     <= 1'b0;
      total_r   <= '0;
      sec_r     <= '0;
      widx_r    <= '0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      writing_r <= writing_nxt;
      bsc_r     <= bsc_nxt;
      total_r   <= total_nxt;
      sec_r     <= sec_nxt;
      widx_r    <= widx_nxt;
    end
  end

endmodule

/* src/ata_seq_emit.sv */
module ata_seq_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                fire,
  input  ata_seq_pkg::job_t                   job,
  output logic                                in_ready,
  input  logic                                out_ready,
  output logic                                out_valid,
  output ata_seq_pkg::res_t                   out_res,
  output logic                                out_last,
  output logic [ata_seq_pkg::N_W-1:0]         rem
);

  ata_seq_pkg::res_t [ata_seq_pkg::MAX_RESULTS-1:0] list_r, list_nxt;
  logic [ata_seq_pkg::N_W-1:0]                      rem_r;
  logic                                             out_valid_r;
  ata_seq_pkg::res_t                                out_res_r;
  logic                                             out_last_r;
  logic                                             move;
  logic                                             final_one;

  assign final_one = (rem_r == ata_seq_pkg::N_W'(1));
  assign move      = (rem_r != '0) && (!out_valid_r || out_ready);
  assign in_ready  = (rem_r == '0) || (final_one && move);

  // pending results advance toward slot 0
  always_comb begin
    for (int i = 0; i < ata_seq_pkg::MAX_RESULTS - 1; i++) begin
      list_nxt[i] = list_r[i+1];
    end
    list_nxt[ata_seq_pkg::MAX_RESULTS-1] = '0;
  end

  always_ff @(posedge clk) begin
    if (fire && job.load) begin
      list_r <= job.list;
    end else if (move) begin
      list_r <= list_nxt;
    end
    if (move) begin
      out_res_r  <= list_r[0];
      out_last_r <= final_one;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire && job.load) begin
        rem_r <= job.n;
      end else if (move) begin
        rem_r <= rem_r - ata_seq_pkg::N_W'(1);
      end
      if (move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;
  assign rem       = rem_r;

endmodule

/* src/ata_pio_lba28_transfer_sequencer.sv */
// Output: an accepted item's results are written into the pending result list and from
//   there move one at a time into the output register while the output is not stalled.
// Throughput: one item per cycle when it causes one result or none and the output is
//   not stalled; items causing more hold the input until the single output register
//   drains the pending result list (results: request 8 or 1, data word 2, status 1).
// Reset: synchronous, active low; clears phase and counters, sets io_base to 0x1F0
//   and control_port to 0x3F6, and empties the result list and invalidates the output.
`include "ata_pio_lba28_transfer_sequencer_macros.svh"

module ata_pio_lba28_transfer_sequencer (
  input  logic                              clk,
  input  logic                              rst_n,
  ata_seq_in_if.sink                        in_if,
  ata_seq_out_if.source                     out_if,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [ata_seq_pkg::ADDR_W-1:0]    paddr,
  input  logic [ata_seq_pkg::DATA_W-1:0]    pwdata,
  output logic [ata_seq_pkg::DATA_W-1:0]    prdata,
  output logic                              pready
);

  ata_seq_pkg::cfg_t              cfg;
  ata_seq_pkg::item_t             item;
  ata_seq_pkg::job_t              job;
  ata_seq_pkg::res_t              out_res;
  logic                           in_ready;
  logic                           in_fire;
  logic [ata_seq_pkg::N_W-1:0]    rem_cnt;
  logic                           load_fire;
  logic                           out_done;
  logic                           out_wr;

  // register file never stalls the bus
  assign pready = 1'b1;

  ata_seq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign item.cmd         = in_if.cmd;
  assign item.lba         = in_if.lba;
  assign item.count       = in_if.count;
  assign item.status_byte = in_if.status_byte;
  assign item.data_word   = in_if.data_word;

  assign in_if.ready = in_ready;
  assign in_fire     = in_if.valid && in_ready;

  // Decode the accepted item against the phase state and build its result list;
  // sequencer state moves on at the same edge so the next item sees it at once.
  ata_seq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (in_fire),
    .item  (item),
    .cfg   (cfg),
    .job   (job)
  );

  // Holds the pending results and feeds them one per cycle into the output register while the output is not stalled.
  // A new item is taken when the list is empty or while its final pending result moves out.
  ata_seq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (in_fire),
    .job       (job),
    .in_ready  (in_ready),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_res   (out_res),
    .out_last  (out_if.last),
    .rem       (rem_cnt)
  );

  assign out_if.kind  = out_res.kind;
  assign out_if.port  = out_res.port;
  assign out_if.value = out_res.value;

  assign load_fire = in_fire && job.load;
  assign out_done  = (out_if.kind == ata_seq_pkg::K_DONE_OK) ||
                     (out_if.kind == ata_seq_pkg::K_DONE_ERR);
  assign out_wr    = (out_if.kind == ata_seq_pkg::K_PORT_WRITE);

  // a loaded list is exactly as long as the decoder said
  `ATA_ASSERT_PROP(a_list_len, clk, rst_n, load_fire |=> (rem_cnt == $past(job.n)), "list length")

  // completions always close an item
  `ATA_ASSERT_PROP(a_done_last, clk, rst_n, (out_if.valid && out_done) |-> out_if.last, "done not last")

  // a port write is always followed by another result of the same item
  `ATA_ASSERT_NEVER(a_write_not_last, clk, rst_n, out_if.valid && out_if.last && out_wr, "write last")

endmodule
